// ----- hdl/amrt_pkg.sv -----
// shared types, register codes and test codes for the refinement tagger
// no dependencies; every other file refers to this package by scoped names
`timescale 1ns / 1ps
`default_nettype none

package amrt_pkg;

  localparam int unsigned SPACE_DIMS_DEF = 3;
  localparam int unsigned MAX_NBR        = 6;

  localparam int unsigned VAL_W      = 32;
  localparam int unsigned TAG_W      = 8;
  localparam int unsigned LEVEL_W    = 4;
  localparam int unsigned MAXLEV_W   = 5;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_TEST_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TIME    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TIME    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEREFINE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TAG_VALUE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_VALUE = 3'd7;

  // test codes
  localparam logic [MODE_W-1:0] MODE_GRADIENT     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REL_GRADIENT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LESS         = 3'd2;
  localparam logic [MODE_W-1:0] MODE_GREATER      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_VORTICITY    = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]         test_mode;
    logic signed [VAL_W-1:0]   threshold;
    logic [MAXLEV_W-1:0]       max_level;
    logic [VAL_W-1:0]          min_time;
    logic [VAL_W-1:0]          max_time;
    logic                      derefine;
    logic signed [TAG_W-1:0]   tag_value;
    logic signed [TAG_W-1:0]   clear_value;
  } cfg_t;

  // after the difference stage
  typedef struct packed {
    logic                      gate;
    logic                      block;
    logic signed [VAL_W-1:0]   centre;
    logic [VAL_W-1:0]          centre_abs;
    logic [LEVEL_W-1:0]        level;
  } s1_t;

  // after the reduce stage
  typedef struct packed {
    logic                      gate;
    logic                      block;
    logic signed [VAL_W-1:0]   centre;
    logic [VAL_W-1:0]          gmax;
    logic signed [2*VAL_W-1:0] rel_rhs;
    logic signed [VAL_W-1:0]   vort_thr;
  } s2_t;

endpackage

`default_nettype wire

// ----- hdl/amr_cell_refinement_tagger_top.sv -----
// registers: one per stage, between input transfer and result valid
// throughput: one cell per cycle; a stalled output backs up through the stages
// reset: valid bits cleared, config registers return to their reset values
// top level: config registers and the three stage pipeline
// uses amrt_pkg, amrt_diff_stage, amrt_reduce_stage, amrt_decide_stage
`timescale 1ns / 1ps
`default_nettype none

module amr_cell_refinement_tagger_top #(
  parameter int unsigned SpaceDims = amrt_pkg::SPACE_DIMS_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [amrt_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic [amrt_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  wire logic                                   in_valid_i,
  output      logic                                   in_ready_o,
  input  wire logic signed [amrt_pkg::VAL_W-1:0]      centre_i,
  input  wire logic signed [amrt_pkg::VAL_W-1:0]      x_plus_i,
  input  wire logic signed [amrt_pkg::VAL_W-1:0]      x_minus_i,
  input  wire logic signed [amrt_pkg::VAL_W-1:0]      y_plus_i,
  input  wire logic signed [amrt_pkg::VAL_W-1:0]      y_minus_i,
  input  wire logic signed [amrt_pkg::VAL_W-1:0]      z_plus_i,
  input  wire logic signed [amrt_pkg::VAL_W-1:0]      z_minus_i,
  input  wire logic [amrt_pkg::MAX_NBR-1:0]           link_bits_i,
  input  wire logic                                   covered_i,
  input  wire logic                                   boundary_mode_i,
  input  wire logic [amrt_pkg::LEVEL_W-1:0]           level_i,
  input  wire logic [amrt_pkg::VAL_W-1:0]             time_req_i,
  output      logic                                   out_valid_o,
  input  wire logic                                   out_ready_i,
  output      logic                                   tag_write_o,
  output      logic signed [amrt_pkg::TAG_W-1:0]      tag_out_o
);

  localparam int unsigned NumNbr = 2 * SpaceDims;

  amrt_pkg::cfg_t                   cfg_q;
  logic signed [amrt_pkg::VAL_W-1:0] nbr [amrt_pkg::MAX_NBR];

  logic                             s1_valid, s1_ready;
  amrt_pkg::s1_t                    s1_data;
  logic [amrt_pkg::VAL_W-1:0]       s1_diff [NumNbr];
  logic                             s2_valid, s2_ready;
  amrt_pkg::s2_t                    s2_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.test_mode   <= amrt_pkg::MODE_GRADIENT;
      cfg_q.threshold   <= '0;
      cfg_q.max_level   <= '0;
      cfg_q.min_time    <= '0;
      cfg_q.max_time    <= '1;
      cfg_q.derefine    <= 1'b0;
      cfg_q.tag_value   <= 8'sd1;
      cfg_q.clear_value <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        amrt_pkg::CFG_TEST_MODE:   cfg_q.test_mode   <= cfg_data_i[amrt_pkg::MODE_W-1:0];
        amrt_pkg::CFG_THRESHOLD:   cfg_q.threshold   <= cfg_data_i[amrt_pkg::VAL_W-1:0];
        amrt_pkg::CFG_MAX_LEVEL:   cfg_q.max_level   <= cfg_data_i[amrt_pkg::MAXLEV_W-1:0];
        amrt_pkg::CFG_MIN_TIME:    cfg_q.min_time    <= cfg_data_i[amrt_pkg::VAL_W-1:0];
        amrt_pkg::CFG_MAX_TIME:    cfg_q.max_time    <= cfg_data_i[amrt_pkg::VAL_W-1:0];
        amrt_pkg::CFG_DEREFINE:    cfg_q.derefine    <= cfg_data_i[0];
        amrt_pkg::CFG_TAG_VALUE:   cfg_q.tag_value   <= cfg_data_i[amrt_pkg::TAG_W-1:0];
        amrt_pkg::CFG_CLEAR_VALUE: cfg_q.clear_value <= cfg_data_i[amrt_pkg::TAG_W-1:0];
        default: ;
      endcase
    end
  end

  // neighbour order matches the link bit order
  assign nbr[0] = x_plus_i;
  assign nbr[1] = x_minus_i;
  assign nbr[2] = y_plus_i;
  assign nbr[3] = y_minus_i;
  assign nbr[4] = z_plus_i;
  assign nbr[5] = z_minus_i;

  amrt_diff_stage #(
    .SpaceDims(SpaceDims)
  ) u_diff (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (in_valid_i),
    .ready_o        (in_ready_o),
    .centre_i       (centre_i),
    .nbr_i          (nbr),
    .link_bits_i    (link_bits_i),
    .covered_i      (covered_i),
    .boundary_mode_i(boundary_mode_i),
    .level_i        (level_i),
    .time_req_i     (time_req_i),
    .cfg_i          (cfg_q),
    .valid_o        (s1_valid),
    .ready_i        (s1_ready),
    .data_o         (s1_data),
    .diff_o         (s1_diff)
  );

  amrt_reduce_stage #(
    .SpaceDims(SpaceDims)
  ) u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s1_valid),
    .ready_o(s1_ready),
    .data_i (s1_data),
    .diff_i (s1_diff),
    .cfg_i  (cfg_q),
    .valid_o(s2_valid),
    .ready_i(s2_ready),
    .data_o (s2_data)
  );

  amrt_decide_stage u_decide (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s2_valid),
    .ready_o    (s2_ready),
    .data_i     (s2_data),
    .cfg_i      (cfg_q),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .tag_write_o(tag_write_o),
    .tag_out_o  (tag_out_o)
  );

endmodule

`default_nettype wire

// ----- hdl/amrt_diff_stage.sv -----
// first stage: absolute neighbour differences, link masking, level and time gates
// uses amrt_pkg
`timescale 1ns / 1ps
`default_nettype none

module amrt_diff_stage #(
  parameter int unsigned SpaceDims = amrt_pkg::SPACE_DIMS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  valid_i,
  output      logic                                  ready_o,
  input  wire logic signed [amrt_pkg::VAL_W-1:0]     centre_i,
  input  wire logic signed [amrt_pkg::VAL_W-1:0]     nbr_i [amrt_pkg::MAX_NBR],
  input  wire logic [amrt_pkg::MAX_NBR-1:0]          link_bits_i,
  input  wire logic                                  covered_i,
  input  wire logic                                  boundary_mode_i,
  input  wire logic [amrt_pkg::LEVEL_W-1:0]          level_i,
  input  wire logic [amrt_pkg::VAL_W-1:0]            time_req_i,
  input  wire amrt_pkg::cfg_t                        cfg_i,
  output      logic                                  valid_o,
  input  wire logic                                  ready_i,
  output      amrt_pkg::s1_t                         data_o,
  output      logic [amrt_pkg::VAL_W-1:0]            diff_o [2*SpaceDims]
);

  localparam int unsigned NumNbr = 2 * SpaceDims;

  logic                          valid_q;
  amrt_pkg::s1_t                 data_d, data_q;
  logic [amrt_pkg::VAL_W-1:0]    diff_d [NumNbr];
  logic [amrt_pkg::VAL_W-1:0]    diff_q [NumNbr];

  assign ready_o = !valid_q || ready_i;

  for (genvar g = 0; g < NumNbr; g++) begin : g_dir
    logic signed [amrt_pkg::VAL_W:0] sub;
    logic [amrt_pkg::VAL_W:0]        mag;
    assign sub = {nbr_i[g][amrt_pkg::VAL_W-1], nbr_i[g]} -
                 {centre_i[amrt_pkg::VAL_W-1], centre_i};
    assign mag = sub[amrt_pkg::VAL_W] ? (~sub + 1'b1) : sub;
    // in boundary mode an unlinked neighbour counts as zero difference
    assign diff_d[g] = (!boundary_mode_i || link_bits_i[g]) ? mag[amrt_pkg::VAL_W-1:0] : '0;
  end

  always_comb begin
    data_d.gate       = ({1'b0, level_i} < cfg_i.max_level) &&
                        (time_req_i >= cfg_i.min_time) && (time_req_i <= cfg_i.max_time);
    data_d.block      = boundary_mode_i && covered_i;
    data_d.centre     = centre_i;
    data_d.centre_abs = centre_i[amrt_pkg::VAL_W-1] ? (~centre_i + 1'b1) : centre_i;
    data_d.level      = level_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
      diff_q <= diff_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign diff_o  = diff_q;

endmodule

`default_nettype wire

// ----- hdl/amrt_reduce_stage.sv -----
// second stage: largest difference, threshold times centre magnitude, level-scaled threshold
// uses amrt_pkg
`timescale 1ns / 1ps
`default_nettype none

module amrt_reduce_stage #(
  parameter int unsigned SpaceDims = amrt_pkg::SPACE_DIMS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output      logic                        ready_o,
  input  wire amrt_pkg::s1_t               data_i,
  input  wire logic [amrt_pkg::VAL_W-1:0]  diff_i [2*SpaceDims],
  input  wire amrt_pkg::cfg_t              cfg_i,
  output      logic                        valid_o,
  input  wire logic                        ready_i,
  output      amrt_pkg::s2_t               data_o
);

  localparam int unsigned NumNbr = 2 * SpaceDims;
  localparam int unsigned VW     = amrt_pkg::VAL_W;
  localparam int unsigned ShW    = VW + (1 << amrt_pkg::LEVEL_W) - 1;

  logic                     valid_q;
  amrt_pkg::s2_t            data_d, data_q;
  logic [VW-1:0]            gmax;
  logic signed [2*VW:0]     prod;
  logic signed [ShW-1:0]    scaled;
  logic                     fits;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    gmax = '0;
    for (int n = 0; n < NumNbr; n++) begin
      if (diff_i[n] > gmax) begin
        gmax = diff_i[n];
      end
    end
  end

  assign prod   = cfg_i.threshold * $signed({1'b0, data_i.centre_abs});
  assign scaled = $signed({{(ShW-VW){cfg_i.threshold[VW-1]}}, cfg_i.threshold}) <<< data_i.level;
  // upper bits all copies of the sign: the scaled value fits in 32 bits
  assign fits   = (&scaled[ShW-1:VW-1]) || !(|scaled[ShW-1:VW-1]);

  always_comb begin
    data_d.gate    = data_i.gate;
    data_d.block   = data_i.block;
    data_d.centre  = data_i.centre;
    data_d.gmax    = gmax;
    data_d.rel_rhs = prod[2*VW-1:0];
    if (fits) begin
      data_d.vort_thr = scaled[VW-1:0];
    end else if (cfg_i.threshold[VW-1]) begin
      data_d.vort_thr = {1'b1, {(VW-1){1'b0}}};
    end else begin
      data_d.vort_thr = {1'b0, {(VW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ----- hdl/amrt_decide_stage.sv -----
// third stage: test selection, final compare and the output register
// uses amrt_pkg
`timescale 1ns / 1ps
`default_nettype none

module amrt_decide_stage (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                valid_i,
  output      logic                                ready_o,
  input  wire amrt_pkg::s2_t                       data_i,
  input  wire amrt_pkg::cfg_t                      cfg_i,
  output      logic                                valid_o,
  input  wire logic                                ready_i,
  output      logic                                tag_write_o,
  output      logic signed [amrt_pkg::TAG_W-1:0]   tag_out_o
);

  localparam int unsigned VW = amrt_pkg::VAL_W;

  logic                                valid_q;
  logic                                hit;
  logic                                tag_write_q;
  logic signed [amrt_pkg::TAG_W-1:0]   tag_out_d, tag_out_q;
  logic signed [VW+1:0]                grad_lhs, grad_rhs;
  logic signed [2*VW-1:0]              rel_lhs;
  logic signed [VW-1:0]                thr;
  logic signed [VW-1:0]                c;

  assign ready_o  = !valid_q || ready_i;
  assign thr      = cfg_i.threshold;
  assign c        = data_i.centre;
  assign grad_lhs = $signed({2'b00, data_i.gmax});
  assign grad_rhs = $signed({{2{thr[VW-1]}}, thr});
  // gmax in q48.16 against threshold times |centre|
  assign rel_lhs  = $signed({{(VW/2){1'b0}}, data_i.gmax, {(VW/2){1'b0}}});

  always_comb begin
    hit = 1'b0;
    unique case (cfg_i.test_mode)
      amrt_pkg::MODE_GRADIENT:     hit = grad_lhs >= grad_rhs;
      amrt_pkg::MODE_REL_GRADIENT: hit = rel_lhs >= data_i.rel_rhs;
      amrt_pkg::MODE_LESS:         hit = !data_i.block && (c <= thr);
      amrt_pkg::MODE_GREATER:      hit = !data_i.block && (c >= thr);
      amrt_pkg::MODE_VORTICITY:    hit = !data_i.block && (c >= $signed(data_i.vort_thr));
      default:                     hit = 1'b0;
    endcase
    hit = hit && data_i.gate;
    if (!hit) begin
      tag_out_d = '0;
    end else if (cfg_i.derefine) begin
      tag_out_d = cfg_i.clear_value;
    end else begin
      tag_out_d = cfg_i.tag_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      tag_write_q <= hit;
      tag_out_q   <= tag_out_d;
    end
  end

  assign valid_o     = valid_q;
  assign tag_write_o = tag_write_q;
  assign tag_out_o   = tag_out_q;

  // no marker without a write
  a_quiet_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !tag_write_q) |-> (tag_out_q == '0))
    else $error("marker nonzero without tag write");

  a_marker_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && tag_write_q) |->
      (tag_out_q == (cfg_i.derefine ? cfg_i.clear_value : cfg_i.tag_value)))
    else $error("marker does not match derefine selection");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ready_i) |=> (valid_q && $stable(tag_write_q) && $stable(tag_out_q)))
    else $error("result changed while stalled");

endmodule

`default_nettype wire
